@@ rtl/lookahead_point_finder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Look-ahead point finder: assertion macros
// Concurrent checks on i_clk, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LOOKAHEAD_POINT_FINDER_TOP_ASSERT_SVH
`define LOOKAHEAD_POINT_FINDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LAPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lapf check failed");
`define LAPF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("lapf check failed");
`else
`define LAPF_ASSERT(lbl, prop)
`define LAPF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/lapf_pkg.sv @@
// ----------------------------------------------------------------------------
// Look-ahead point finder package
// Widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lapf_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int COORD_W     = 21;
    localparam int DIFF_W      = 22;
    localparam int SQ_W        = 44;
    localparam int HEAD_W      = 16;
    localparam int LEN_W       = 20;
    localparam int DIST_W      = 22;
    localparam int NUM_W       = 42;
    localparam int TIDX_W      = 8;
    localparam int STEP_W      = 6;
    localparam int SQRT_STEPS  = 22;
    localparam int SNAP_FINAL  = 655;
    localparam int SNAP_NEAR   = 328;
    localparam int LEN_RESET   = 65536;
    localparam int COORD_MAX   = 1048575;
    localparam int COORD_MIN   = -1048576;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_GOAL,
        KIND_SNAP
    } t_kind;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [HEAD_W-1:0]  h;
    } t_point;

    typedef struct packed {
        logic              wr;
        logic              new_path;
        logic              latch_pose;
        logic              calc_const;
        logic              rd;
        logic [IDX_W-1:0]  rd_addr;
        logic              diff;
        logic              sel_goal;
        logic              square;
        logic              sum;
        logic              latch_tgt;
        logic              sq_init;
        logic              sq_step;
        logic [STEP_W-1:0] step;
        logic              goal_tgt;
        logic              div_mul;
        logic              div_add;
        logic              div_step;
        logic              axis_y;
        logic              axis_wr;
        logic              out_load;
        t_kind             out_kind;
        logic [IDX_W-1:0]  out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             le_ll;
        logic             lt_snapf;
        logic             lt_snapn;
        logic             d_zero;
        logic             out_free;
    } t_dp_sts;

endpackage

@@ rtl/lapf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Look-ahead point finder controller
// Sequences load, backward scan, square root, division and snap checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lapf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_op,
    input  logic              i_new_path,
    output logic              o_s_tready,
    input  lapf_pkg::t_dp_sts i_sts,
    output lapf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CONST,
        S_SCAN_RD, S_SCAN_DF, S_SCAN_SQ, S_SCAN_SM, S_SCAN_CMP,
        S_TGT_RD, S_TGT_DF, S_TGT_SQ, S_TGT_SM,
        S_SQ_INIT, S_SQRT, S_CHK_D,
        S_DIV_MUL, S_DIV_ADD, S_DIV, S_AXIS,
        S_FIN_RD, S_FIN_DF1, S_FIN_SQ1, S_FIN_SM1, S_FIN_CHK1,
        S_FIN_DF2, S_FIN_SQ2, S_FIN_SM2, S_FIN_CHK2,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [lapf_pkg::IDX_W-1:0]   r_idx;
    logic [lapf_pkg::IDX_W-1:0]   r_last;
    logic [lapf_pkg::IDX_W-1:0]   r_tgt;
    logic [lapf_pkg::STEP_W-1:0]  r_step;
    logic                         r_axis;
    lapf_pkg::t_kind              r_kind;

    logic accept;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = o_s_tready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_last  <= '0;
            r_tgt   <= '0;
            r_step  <= '0;
            r_axis  <= 1'b0;
            r_kind  <= lapf_pkg::KIND_EMPTY;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_op == lapf_pkg::OP_QUERY)) begin
                        if (i_sts.count == '0) begin
                            r_kind  <= lapf_pkg::KIND_EMPTY;
                            r_state <= S_DONE;
                        end else begin
                            r_last  <= lapf_pkg::IDX_W'(i_sts.count - lapf_pkg::CNT_W'(1));
                            r_idx   <= lapf_pkg::IDX_W'(i_sts.count - lapf_pkg::CNT_W'(1));
                            r_state <= S_CONST;
                        end
                    end
                end
                S_CONST:    r_state <= S_SCAN_RD;
                S_SCAN_RD:  r_state <= S_SCAN_DF;
                S_SCAN_DF:  r_state <= S_SCAN_SQ;
                S_SCAN_SQ:  r_state <= S_SCAN_SM;
                S_SCAN_SM:  r_state <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    // hit at 0 or no hit both go to the last point
                    if (i_sts.le_ll) begin
                        if (r_idx == '0 || r_idx == r_last) begin
                            r_tgt <= r_last;
                        end else begin
                            r_tgt <= r_idx + 1'b1;
                        end
                        r_state <= S_TGT_RD;
                    end else if (r_idx == '0) begin
                        r_tgt   <= r_last;
                        r_state <= S_TGT_RD;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_TGT_RD:  r_state <= S_TGT_DF;
                S_TGT_DF:  r_state <= S_TGT_SQ;
                S_TGT_SQ:  r_state <= S_TGT_SM;
                S_TGT_SM:  r_state <= S_SQ_INIT;
                S_SQ_INIT: begin
                    r_step  <= lapf_pkg::STEP_W'(lapf_pkg::SQRT_STEPS - 1);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= S_CHK_D;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_CHK_D: begin
                    r_axis <= 1'b0;
                    if (i_sts.d_zero) begin
                        r_state <= S_FIN_RD;
                    end else begin
                        r_state <= S_DIV_MUL;
                    end
                end
                S_DIV_MUL: r_state <= S_DIV_ADD;
                S_DIV_ADD: begin
                    r_step  <= lapf_pkg::STEP_W'(lapf_pkg::NUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_AXIS;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_AXIS: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_DIV_MUL;
                    end else begin
                        r_state <= S_FIN_RD;
                    end
                end
                S_FIN_RD:  r_state <= S_FIN_DF1;
                S_FIN_DF1: r_state <= S_FIN_SQ1;
                S_FIN_SQ1: r_state <= S_FIN_SM1;
                S_FIN_SM1: r_state <= S_FIN_CHK1;
                S_FIN_CHK1: begin
                    if (i_sts.lt_snapf) begin
                        r_kind  <= lapf_pkg::KIND_SNAP;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FIN_DF2;
                    end
                end
                S_FIN_DF2: r_state <= S_FIN_SQ2;
                S_FIN_SQ2: r_state <= S_FIN_SM2;
                S_FIN_SM2: r_state <= S_FIN_CHK2;
                S_FIN_CHK2: begin
                    r_kind  <= i_sts.lt_snapn ? lapf_pkg::KIND_SNAP : lapf_pkg::KIND_GOAL;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr         = accept && (i_op == lapf_pkg::OP_LOAD);
        o_cmd.new_path   = i_new_path;
        o_cmd.latch_pose = accept && (i_op == lapf_pkg::OP_QUERY);
        o_cmd.calc_const = (r_state == S_CONST);
        o_cmd.rd         = (r_state == S_SCAN_RD) || (r_state == S_TGT_RD)
                           || (r_state == S_FIN_RD);
        o_cmd.rd_addr    = (r_state == S_SCAN_RD) ? r_idx
                           : (r_state == S_TGT_RD) ? r_tgt : r_last;
        o_cmd.diff       = (r_state == S_SCAN_DF) || (r_state == S_TGT_DF)
                           || (r_state == S_FIN_DF1) || (r_state == S_FIN_DF2);
        o_cmd.sel_goal   = (r_state == S_FIN_DF2);
        o_cmd.square     = (r_state == S_SCAN_SQ) || (r_state == S_TGT_SQ)
                           || (r_state == S_FIN_SQ1) || (r_state == S_FIN_SQ2);
        o_cmd.sum        = (r_state == S_SCAN_SM) || (r_state == S_TGT_SM)
                           || (r_state == S_FIN_SM1) || (r_state == S_FIN_SM2);
        o_cmd.latch_tgt  = (r_state == S_TGT_DF);
        o_cmd.sq_init    = (r_state == S_SQ_INIT);
        o_cmd.sq_step    = (r_state == S_SQRT);
        o_cmd.step       = r_step;
        o_cmd.goal_tgt   = (r_state == S_CHK_D) && i_sts.d_zero;
        o_cmd.div_mul    = (r_state == S_DIV_MUL);
        o_cmd.div_add    = (r_state == S_DIV_ADD);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.axis_y     = r_axis;
        o_cmd.axis_wr    = (r_state == S_AXIS);
        o_cmd.out_load   = (r_state == S_DONE) && i_sts.out_free;
        o_cmd.out_kind   = r_kind;
        o_cmd.out_idx    = (r_kind == lapf_pkg::KIND_SNAP) ? r_last
                           : (r_kind == lapf_pkg::KIND_GOAL) ? r_tgt : '0;
    end

endmodule

@@ rtl/lapf_dp.sv @@
// ----------------------------------------------------------------------------
// Look-ahead point finder datapath
// Path store, distance unit, bit-pair square root, restoring divider, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lapf_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lapf_pkg::t_dp_cmd                  i_cmd,
    output lapf_pkg::t_dp_sts                  o_sts,
    input  logic                               i_cfg_wen,
    input  logic [lapf_pkg::LEN_W-1:0]         i_cfg_wdata,
    input  logic signed [lapf_pkg::COORD_W-1:0] i_x,
    input  logic signed [lapf_pkg::COORD_W-1:0] i_y,
    input  logic [lapf_pkg::HEAD_W-1:0]        i_h,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [71:0]                        o_m_tdata,
    output logic [1:0]                         o_m_tuser
);

    localparam int LL_W    = 2 * lapf_pkg::LEN_W;
    localparam int LSNAP_W = 2 * (lapf_pkg::LEN_W + 1);
    localparam int SUM_W   = lapf_pkg::NUM_W + 2;

    // configuration and path bookkeeping
    logic [lapf_pkg::LEN_W-1:0] r_len;
    logic [lapf_pkg::CNT_W-1:0] r_count;
    logic                       r_ovf;

    lapf_pkg::t_point r_mem [lapf_pkg::MAX_POINTS];
    lapf_pkg::t_point r_rd;
    lapf_pkg::t_point r_t;

    logic signed [lapf_pkg::COORD_W-1:0] r_px, r_py, r_gx, r_gy;
    logic [lapf_pkg::HEAD_W-1:0]         r_ph;

    logic [LL_W-1:0]    r_ll;
    logic [LSNAP_W-1:0] r_lsnap;

    logic signed [lapf_pkg::DIFF_W-1:0] r_dx, r_dy;
    logic [lapf_pkg::SQ_W-1:0]          r_sqx, r_sqy, r_s;

    logic [lapf_pkg::SQ_W-1:0]   r_rem, r_root;
    logic [lapf_pkg::NUM_W-1:0]  r_num, r_q;
    logic [lapf_pkg::DIST_W-1:0] r_drem;

    logic                               r_ovalid;
    logic signed [lapf_pkg::COORD_W-1:0] r_ox, r_oy;
    logic [lapf_pkg::HEAD_W-1:0]        r_oh;
    logic [lapf_pkg::TIDX_W-1:0]        r_oidx;
    logic                               r_oempty, r_otrunc;

    logic                         w_en;
    logic [lapf_pkg::IDX_W-1:0]   w_addr;
    logic signed [lapf_pkg::COORD_W-1:0] ax, ay;
    logic [lapf_pkg::LEN_W:0]     len_snap;
    logic [lapf_pkg::SQ_W-1:0]    bitv, trial;
    logic [lapf_pkg::DIST_W-1:0]  root_d;
    logic signed [lapf_pkg::DIFF_W-1:0] tdiff;
    logic [lapf_pkg::DIFF_W-1:0]  mag;
    logic [lapf_pkg::DIST_W:0]    rem_sh;
    logic                         q_bit;
    logic signed [SUM_W-1:0]      pose_ext, q_ext, g_sum;
    logic signed [lapf_pkg::COORD_W-1:0] g_sat, pose_axis;

    assign w_en   = i_cmd.wr && (i_cmd.new_path
                    || r_count < lapf_pkg::CNT_W'(lapf_pkg::MAX_POINTS));
    assign w_addr = i_cmd.new_path ? '0 : r_count[lapf_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= lapf_pkg::LEN_W'(lapf_pkg::LEN_RESET);
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_len <= i_cfg_wdata;
            end
            if (i_cmd.wr) begin
                if (i_cmd.new_path) begin
                    r_count <= lapf_pkg::CNT_W'(1);
                    r_ovf   <= 1'b0;
                end else if (r_count < lapf_pkg::CNT_W'(lapf_pkg::MAX_POINTS)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= '{x: i_x, y: i_y, h: i_h};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
    end

    // distance unit: diff, square, sum over three steps
    assign ax       = i_cmd.sel_goal ? r_gx : r_px;
    assign ay       = i_cmd.sel_goal ? r_gy : r_py;
    assign len_snap = {1'b0, r_len} + (lapf_pkg::LEN_W + 1)'(lapf_pkg::SNAP_FINAL);

    // square root, two bits of radicand a step
    assign bitv   = lapf_pkg::SQ_W'(1) << {i_cmd.step, 1'b0};
    assign trial  = r_root + bitv;
    assign root_d = r_root[lapf_pkg::DIST_W-1:0];

    // divider operands
    assign tdiff = i_cmd.axis_y
                   ? ($signed({r_t.y[lapf_pkg::COORD_W-1], r_t.y})
                      - $signed({r_py[lapf_pkg::COORD_W-1], r_py}))
                   : ($signed({r_t.x[lapf_pkg::COORD_W-1], r_t.x})
                      - $signed({r_px[lapf_pkg::COORD_W-1], r_px}));
    assign mag       = tdiff[lapf_pkg::DIFF_W-1] ? lapf_pkg::DIFF_W'(-tdiff) : tdiff;
    assign rem_sh    = {r_drem, r_num[lapf_pkg::NUM_W-1]};
    assign q_bit     = (rem_sh >= {1'b0, root_d});
    assign pose_axis = i_cmd.axis_y ? r_py : r_px;
    assign pose_ext  = SUM_W'(pose_axis);
    assign q_ext     = $signed({2'b00, r_q});
    assign g_sum     = tdiff[lapf_pkg::DIFF_W-1] ? (pose_ext - q_ext) : (pose_ext + q_ext);
    assign g_sat     = (g_sum > SUM_W'(lapf_pkg::COORD_MAX))
                       ? lapf_pkg::COORD_W'(lapf_pkg::COORD_MAX)
                       : (g_sum < SUM_W'(lapf_pkg::COORD_MIN))
                       ? lapf_pkg::COORD_W'(lapf_pkg::COORD_MIN)
                       : g_sum[lapf_pkg::COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_pose) begin
            r_px <= i_x;
            r_py <= i_y;
            r_ph <= i_h;
        end
        if (i_cmd.calc_const) begin
            r_ll    <= r_len * r_len;
            r_lsnap <= len_snap * len_snap;
        end
        if (i_cmd.diff) begin
            r_dx <= $signed({ax[lapf_pkg::COORD_W-1], ax})
                    - $signed({r_rd.x[lapf_pkg::COORD_W-1], r_rd.x});
            r_dy <= $signed({ay[lapf_pkg::COORD_W-1], ay})
                    - $signed({r_rd.y[lapf_pkg::COORD_W-1], r_rd.y});
        end
        if (i_cmd.square) begin
            r_sqx <= lapf_pkg::SQ_W'(r_dx * r_dx);
            r_sqy <= lapf_pkg::SQ_W'(r_dy * r_dy);
        end
        if (i_cmd.sum) begin
            r_s <= r_sqx + r_sqy;
        end
        if (i_cmd.latch_tgt) begin
            r_t <= r_rd;
        end
        if (i_cmd.sq_init) begin
            r_rem  <= r_s;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + bitv;
            end else begin
                r_root <= r_root >> 1;
            end
        end
        if (i_cmd.div_mul) begin
            r_num <= lapf_pkg::NUM_W'(mag * r_len);
        end else if (i_cmd.div_add) begin
            // half the divisor added first gives round to nearest
            r_num  <= r_num + lapf_pkg::NUM_W'(root_d >> 1);
            r_q    <= '0;
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= r_num << 1;
            r_q    <= {r_q[lapf_pkg::NUM_W-2:0], q_bit};
            r_drem <= q_bit ? lapf_pkg::DIST_W'(rem_sh - {1'b0, root_d})
                            : rem_sh[lapf_pkg::DIST_W-1:0];
        end
        if (i_cmd.goal_tgt) begin
            r_gx <= r_t.x;
            r_gy <= r_t.y;
        end else if (i_cmd.axis_wr) begin
            if (i_cmd.axis_y) begin
                r_gy <= g_sat;
            end else begin
                r_gx <= g_sat;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oidx   <= lapf_pkg::TIDX_W'(i_cmd.out_idx);
            r_otrunc <= r_ovf;
            r_oempty <= (i_cmd.out_kind == lapf_pkg::KIND_EMPTY);
            case (i_cmd.out_kind)
                lapf_pkg::KIND_EMPTY: begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                    r_oh <= r_ph;
                end
                lapf_pkg::KIND_SNAP: begin
                    r_ox <= r_rd.x;
                    r_oy <= r_rd.y;
                    r_oh <= r_rd.h;
                end
                default: begin
                    r_ox <= r_gx;
                    r_oy <= r_gy;
                    r_oh <= r_t.h;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_oidx, r_oh, r_oy, r_ox};
    assign o_m_tuser  = {r_otrunc, r_oempty};

    assign o_sts.count    = r_count;
    assign o_sts.le_ll    = (r_s <= lapf_pkg::SQ_W'(r_ll));
    assign o_sts.lt_snapf = (r_s < lapf_pkg::SQ_W'(r_lsnap));
    assign o_sts.lt_snapn = (r_s < lapf_pkg::SQ_W'(lapf_pkg::SNAP_NEAR
                                                   * lapf_pkg::SNAP_NEAR));
    assign o_sts.d_zero   = (root_d == '0);
    assign o_sts.out_free = !r_ovalid || i_m_tready;

endmodule

@@ rtl/lookahead_point_finder_top.sv @@
// A load is taken in the cycle it is accepted. A query scans the path back from
// its end, then runs the 22-step root and two 42-step divisions through one
// distance unit and a single-port store, skipping the divisions when the target
// lies on the pose; an empty path goes straight to the output. One item at a time.
// Reset (sync, active low) empties the path, clears overflow, sets L to 1.0 m.
`timescale 1ns / 1ps
`include "lookahead_point_finder_top_assert.svh"

// ----------------------------------------------------------------------------
// Look-ahead point finder top level
// Stream wrapper joining the controller and the datapath.
// ----------------------------------------------------------------------------
module lookahead_point_finder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [19:0] i_cfg_wdata,   // lookahead_distance
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,     // coord_x, coord_y, heading, zero pad
    input  logic [1:0]  i_s_tuser,     // operation, new_path
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,     // goal_x, goal_y, goal_heading, target_index, pad
    output logic [1:0]  o_m_tuser      // path_empty, path_truncated
);

    lapf_pkg::t_dp_cmd cmd;
    lapf_pkg::t_dp_sts sts;

    lapf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser[0]),
        .i_new_path (i_s_tuser[1]),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lapf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_x         ($signed(i_s_tdata[20:0])),
        .i_y         ($signed(i_s_tdata[41:21])),
        .i_h         (i_s_tdata[57:42]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    `LAPF_ASSERT(a_query_busy, (i_s_tvalid && o_s_tready && i_s_tuser[0]) |=> !o_s_tready)
    `LAPF_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (!o_m_tvalid && o_s_tready))
    `LAPF_ASSERT(a_empty_idx, (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[65:58] == 8'd0))

endmodule
